FILE: sv/ptld_pkg.sv
// Shared types, codes and constants of the plain text layout detector.
package ptld_pkg;

    localparam int TABLE_SIZE_DEF  = 10;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_W      = 16;
    localparam int INDENT_W   = 4;
    localparam int SHARE_W    = 4;
    localparam int RESULT_W   = 4;
    localparam int GAP_OUT_W  = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SHORT_LINE_LIMIT     = 3'd0;
    localparam cfg_idx_t CFG_LINE_LIMIT           = 3'd1;
    localparam cfg_idx_t CFG_INDENT_SHARE_TENTHS  = 3'd2;
    localparam cfg_idx_t CFG_SHORT_SHARE_TENTHS   = 3'd3;
    localparam cfg_idx_t CFG_SECTION_SHARE_TENTHS = 3'd4;
    localparam cfg_idx_t CFG_SECTION_MIN_COUNT    = 3'd5;

    localparam logic [7:0] RST_SHORT_LINE_LIMIT     = 8'd51;
    localparam logic [7:0] RST_LINE_LIMIT           = 8'd81;
    localparam logic [3:0] RST_INDENT_SHARE_TENTHS  = 4'd1;
    localparam logic [3:0] RST_SHORT_SHARE_TENTHS   = 4'd3;
    localparam logic [3:0] RST_SECTION_SHARE_TENTHS = 4'd7;
    localparam logic [7:0] RST_SECTION_MIN_COUNT    = 8'd2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef struct packed {
        logic [7:0]         short_line_limit;
        logic [7:0]         line_limit;
        logic [SHARE_W-1:0] indent_share_tenths;
        logic [SHARE_W-1:0] short_share_tenths;
        logic [SHARE_W-1:0] section_share_tenths;
        logic [7:0]         section_min_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_BREAK,
        ST_INDENT,
        ST_BEST,
        ST_SECTION,
        ST_EMIT
    } seq_state_t;

endpackage

FILE: sv/ptld_cmp.sv
// Shared share compare unit: 10*a against t*b.
module ptld_cmp #(
    parameter int SUM_W = 36
) (
    input  logic [SUM_W-1:0]            a,
    input  logic [ptld_pkg::SHARE_W-1:0] t,
    input  logic [SUM_W-1:0]            b,
    output logic                        gt,
    output logic                        lt
);

    localparam int PW = SUM_W + ptld_pkg::SHARE_W;

    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    logic [PW-1:0] a_ext;
    logic [PW-1:0] b_ext;

    always_comb begin
        a_ext = PW'(a);
        b_ext = PW'(b);
        lhs   = (a_ext << 3) + (a_ext << 1);
        rhs   = '0;
        for (int k = 0; k < ptld_pkg::SHARE_W; k++) begin
            if (t[k]) begin
                rhs = rhs + (b_ext << k);
            end
        end
        gt = lhs > rhs;
        lt = lhs < rhs;
    end

endmodule

FILE: sv/ptld_stats.sv
// Line tracker, saturating line counters and the three histograms.
module ptld_stats #(
    parameter int TABLE_SIZE  = ptld_pkg::TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = ptld_pkg::COUNT_WIDTH_DEF,
    localparam int IW = $clog2(TABLE_SIZE)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_en,
    input  logic [7:0]             text_byte,
    input  logic                   clear,
    input  ptld_pkg::cfg_t         cfg,
    input  logic                   scan_en,
    input  logic [IW-1:0]          scan_idx,
    output logic [COUNT_WIDTH-1:0] ih_bin,
    output logic [COUNT_WIDTH-1:0] gh_bin,
    output logic [COUNT_WIDTH-1:0] sh_bin,
    output logic [COUNT_WIDTH-1:0] non_empty,
    output logic [COUNT_WIDTH-1:0] not_long_total
);

    localparam int W = COUNT_WIDTH;
    localparam logic [W-1:0] CMAX = '1;
    localparam logic [W-1:0] CMAX_M1 = CMAX - W'(1);
    localparam logic [IW-1:0] LAST_BIN = IW'(TABLE_SIZE - 1);
    localparam int LW = ptld_pkg::LEN_W;
    localparam int DW = ptld_pkg::INDENT_W;

    logic [W-1:0]  ih_reg [TABLE_SIZE];
    logic [W-1:0]  gh_reg [TABLE_SIZE];
    logic [W-1:0]  sh_reg [TABLE_SIZE];

    logic [W-1:0]  line_total_reg, line_total_next;
    logic [W-1:0]  empty_total_reg, empty_total_next;
    logic [W-1:0]  not_long_reg, not_long_next;
    logic          line_is_empty_reg, line_is_empty_next;
    logic [LW-1:0] line_length_reg, line_length_next;
    logic [DW-1:0] line_indent_reg, line_indent_next;
    logic [IW-1:0] gap_run_reg, gap_run_next;
    logic          gap_none_reg, gap_none_next;

    logic [LW-1:0] len_inc;
    logic          is_lf;
    logic          is_cr;
    logic          is_ws;
    logic [IW-1:0] ind_idx;
    logic [IW-1:0] ih_addr;
    logic [IW-1:0] gh_addr;
    logic          bump_ind;
    logic          bump_gap;
    logic          bump_short;

    always_comb begin
        len_inc = (line_length_reg == '1) ? line_length_reg : line_length_reg + LW'(1);
        is_lf   = text_byte == ptld_pkg::CH_LF;
        is_cr   = text_byte == ptld_pkg::CH_CR;
        is_ws   = text_byte == ptld_pkg::CH_SP || text_byte == ptld_pkg::CH_HT ||
                  text_byte == ptld_pkg::CH_VT || text_byte == ptld_pkg::CH_FF;
        ind_idx = (int'(line_indent_reg) > TABLE_SIZE - 1) ? LAST_BIN : IW'(line_indent_reg);

        ih_addr = scan_en ? scan_idx : ind_idx;
        gh_addr = scan_en ? scan_idx : gap_run_reg;
        ih_bin  = ih_reg[ih_addr];
        gh_bin  = gh_reg[gh_addr];
        sh_bin  = sh_reg[gh_addr];

        line_total_next    = line_total_reg;
        empty_total_next   = empty_total_reg;
        not_long_next      = not_long_reg;
        line_is_empty_next = line_is_empty_reg;
        line_length_next   = line_length_reg;
        line_indent_next   = line_indent_reg;
        gap_run_next       = gap_run_reg;
        gap_none_next      = gap_none_reg;
        bump_ind           = 1'b0;
        bump_gap           = 1'b0;
        bump_short         = 1'b0;

        if (byte_en) begin
            line_length_next = len_inc;
            if (is_lf) begin
                line_total_next = (line_total_reg == CMAX) ? CMAX : line_total_reg + W'(1);
                if (line_is_empty_reg) begin
                    // all ones stands for minus one, so the first empty line lands on zero
                    if (empty_total_reg == CMAX) begin
                        empty_total_next = '0;
                    end else if (empty_total_reg < CMAX_M1) begin
                        empty_total_next = empty_total_reg + W'(1);
                    end
                    if (gap_none_reg) begin
                        gap_run_next  = '0;
                        gap_none_next = 1'b0;
                    end else if (gap_run_reg != LAST_BIN) begin
                        gap_run_next = gap_run_reg + IW'(1);
                    end
                end else begin
                    bump_ind      = 1'b1;
                    bump_gap      = !gap_none_reg;
                    bump_short    = !gap_none_reg && (len_inc < LW'(cfg.short_line_limit));
                    gap_none_next = 1'b1;
                end
                if (len_inc < LW'(cfg.line_limit)) begin
                    not_long_next = (not_long_reg == CMAX) ? CMAX : not_long_reg + W'(1);
                end
                line_is_empty_next = 1'b1;
                line_length_next   = '0;
                line_indent_next   = '0;
            end else if (is_cr) begin
                line_length_next = len_inc;
            end else if (is_ws) begin
                if (line_is_empty_reg && line_indent_reg != '1) begin
                    line_indent_next = line_indent_reg + DW'(1);
                end
            end else begin
                line_is_empty_next = 1'b0;
            end
        end

        non_empty      = line_total_reg - empty_total_reg;
        not_long_total = not_long_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                ih_reg[i] <= '0;
                gh_reg[i] <= '0;
                sh_reg[i] <= '0;
            end
            line_total_reg    <= '0;
            empty_total_reg   <= CMAX;
            not_long_reg      <= '0;
            line_is_empty_reg <= 1'b1;
            line_length_reg   <= '0;
            line_indent_reg   <= '0;
            gap_run_reg       <= '0;
            gap_none_reg      <= 1'b1;
        end else begin
            line_total_reg    <= line_total_next;
            empty_total_reg   <= empty_total_next;
            not_long_reg      <= not_long_next;
            line_is_empty_reg <= line_is_empty_next;
            line_length_reg   <= line_length_next;
            line_indent_reg   <= line_indent_next;
            gap_run_reg       <= gap_run_next;
            gap_none_reg      <= gap_none_next;
            if (bump_ind) begin
                ih_reg[ind_idx] <= (ih_bin == CMAX) ? CMAX : ih_bin + W'(1);
            end
            if (bump_gap) begin
                gh_reg[gap_run_reg] <= (gh_bin == CMAX) ? CMAX : gh_bin + W'(1);
            end
            if (bump_short) begin
                sh_reg[gap_run_reg] <= (sh_bin == CMAX) ? CMAX : sh_bin + W'(1);
            end
        end
    end

    a_no_lines_no_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        line_total_reg == '0 |-> empty_total_reg == CMAX)
        else $error("empty line count moved without a line");

    a_clear_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> line_total_reg == '0 && line_is_empty_reg && gap_none_reg)
        else $error("line state survived a clear");

endmodule

FILE: sv/ptld_seq.sv
// Scan sequencer: walks the histograms through the shared compare unit and holds the result.
module ptld_seq #(
    parameter int TABLE_SIZE  = ptld_pkg::TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = ptld_pkg::COUNT_WIDTH_DEF,
    localparam int IW = $clog2(TABLE_SIZE)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              end_accepted,
    input  ptld_pkg::cfg_t                    cfg,
    input  logic [COUNT_WIDTH-1:0]            ih_bin,
    input  logic [COUNT_WIDTH-1:0]            gh_bin,
    input  logic [COUNT_WIDTH-1:0]            sh_bin,
    input  logic [COUNT_WIDTH-1:0]            non_empty,
    input  logic [COUNT_WIDTH-1:0]            not_long_total,
    output logic                              run,
    output logic                              clear,
    output logic [IW-1:0]                     scan_idx,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ptld_pkg::RESULT_W-1:0]     m_ignored_indent,
    output logic                              m_break_on_empty_line,
    output logic                              m_break_on_newline,
    output logic                              m_break_on_indented_line,
    output logic signed [ptld_pkg::GAP_OUT_W-1:0] m_section_gap_lines,
    output logic                              m_make_contents
);

    localparam int W  = COUNT_WIDTH;
    localparam int SW = COUNT_WIDTH + $clog2(TABLE_SIZE);
    localparam int RW = ptld_pkg::RESULT_W;
    localparam int GW = ptld_pkg::GAP_OUT_W;
    localparam logic [IW-1:0] LAST_BIN  = IW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] FIRST_SEC = IW'(2);
    localparam logic [RW-1:0] IND_NONE  =
        (TABLE_SIZE + 1 > 15) ? RW'(15) : RW'(TABLE_SIZE + 1);
    localparam logic [GW-1:0] GAP_NONE  = '1;

    ptld_pkg::seq_state_t state_reg, state_next;

    logic [IW-1:0] idx_reg, idx_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] sacc_reg, sacc_next;
    logic [W-1:0]  best_reg, best_next;
    logic [IW-1:0] start_reg, start_next;
    logic          found_reg, found_next;
    logic [IW-1:0] res_reg, res_next;
    logic          res_found_reg, res_found_next;
    logic          brk_reg, brk_next;
    logic [RW-1:0] ind_reg, ind_next;

    logic          m_valid_reg, m_valid_next;
    logic [RW-1:0] m_ind_reg, m_ind_next;
    logic          m_brk_reg, m_brk_next;
    logic [GW-1:0] m_gap_reg, m_gap_next;
    logic          m_mc_reg, m_mc_next;

    logic [SW-1:0] cmp_a;
    logic [SW-1:0] cmp_b;
    logic [ptld_pkg::SHARE_W-1:0] cmp_t;
    logic          cmp_gt;
    logic          cmp_lt;
    logic [SW-1:0] cum;
    logic [SW-1:0] ga_sum;
    logic [SW-1:0] sa_sum;
    logic [RW-1:0] ind_hit;
    logic [GW-1:0] gap_val;

    ptld_cmp #(
        .SUM_W (SW)
    ) u_cmp (
        .a  (cmp_a),
        .t  (cmp_t),
        .b  (cmp_b),
        .gt (cmp_gt),
        .lt (cmp_lt)
    );

    always_comb begin
        cum     = acc_reg + SW'(ih_bin);
        ga_sum  = acc_reg + SW'(gh_bin);
        sa_sum  = sacc_reg + SW'(sh_bin);
        ind_hit = (int'(idx_reg) + 1 > 15) ? RW'(15) : RW'(int'(idx_reg) + 1);
        gap_val = !res_found_reg ? GAP_NONE :
                  (int'(res_reg) > 15) ? GW'(15) : GW'(res_reg);

        // the compare unit serves one pass at a time
        case (state_reg)
            ptld_pkg::ST_BREAK: begin
                cmp_a = SW'(not_long_total);
                cmp_t = cfg.short_share_tenths;
                cmp_b = SW'(non_empty);
            end
            ptld_pkg::ST_INDENT: begin
                cmp_a = cum;
                cmp_t = cfg.indent_share_tenths;
                cmp_b = SW'(non_empty);
            end
            ptld_pkg::ST_SECTION: begin
                cmp_a = sa_sum;
                cmp_t = cfg.section_share_tenths;
                cmp_b = ga_sum;
            end
            default: begin
                cmp_a = '0;
                cmp_t = '0;
                cmp_b = '0;
            end
        endcase

        state_next     = state_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        sacc_next      = sacc_reg;
        best_next      = best_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        res_found_next = res_found_reg;
        brk_next       = brk_reg;
        ind_next       = ind_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ind_next     = m_ind_reg;
        m_brk_next     = m_brk_reg;
        m_gap_next     = m_gap_reg;
        m_mc_next      = m_mc_reg;
        clear          = 1'b0;

        case (state_reg)
            ptld_pkg::ST_RUN: begin
                if (end_accepted) begin
                    state_next = ptld_pkg::ST_BREAK;
                end
            end
            ptld_pkg::ST_BREAK: begin
                brk_next   = !cmp_lt;
                idx_next   = '0;
                acc_next   = '0;
                state_next = ptld_pkg::ST_INDENT;
            end
            ptld_pkg::ST_INDENT: begin
                acc_next = cum;
                if (cmp_gt) begin
                    ind_next = ind_hit;
                end else if (idx_reg == LAST_BIN) begin
                    ind_next = IND_NONE;
                end
                if (cmp_gt || idx_reg == LAST_BIN) begin
                    idx_next   = FIRST_SEC;
                    best_next  = '0;
                    found_next = 1'b0;
                    state_next = ptld_pkg::ST_BEST;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ptld_pkg::ST_BEST: begin
                // strict compare keeps the first of equal bins
                if (sh_bin > best_reg) begin
                    best_next  = sh_bin;
                    start_next = idx_reg;
                    found_next = 1'b1;
                end
                if (idx_reg == LAST_BIN) begin
                    acc_next       = '0;
                    sacc_next      = '0;
                    res_found_next = 1'b0;
                    state_next     = ptld_pkg::ST_SECTION;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ptld_pkg::ST_SECTION: begin
                // walk down from the last bin; the lowest qualifying index wins
                if (!found_reg) begin
                    state_next = ptld_pkg::ST_EMIT;
                end else begin
                    acc_next  = ga_sum;
                    sacc_next = sa_sum;
                    if (sa_sum > SW'(cfg.section_min_count) && cmp_gt) begin
                        res_next       = idx_reg;
                        res_found_next = 1'b1;
                    end
                    if (idx_reg == start_reg) begin
                        state_next = ptld_pkg::ST_EMIT;
                    end else begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            ptld_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ind_next   = ind_reg;
                    m_brk_next   = brk_reg;
                    m_gap_next   = gap_val;
                    m_mc_next    = res_found_reg;
                    clear        = 1'b1;
                    state_next   = ptld_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = ptld_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptld_pkg::ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        acc_reg       <= acc_next;
        sacc_reg      <= sacc_next;
        best_reg      <= best_next;
        start_reg     <= start_next;
        found_reg     <= found_next;
        res_reg       <= res_next;
        res_found_reg <= res_found_next;
        brk_reg       <= brk_next;
        ind_reg       <= ind_next;
        m_ind_reg     <= m_ind_next;
        m_brk_reg     <= m_brk_next;
        m_gap_reg     <= m_gap_next;
        m_mc_reg      <= m_mc_next;
    end

    assign run                      = state_reg == ptld_pkg::ST_RUN;
    assign scan_idx                 = idx_reg;
    assign m_valid                  = m_valid_reg;
    assign m_ignored_indent         = m_ind_reg;
    assign m_break_on_empty_line    = 1'b1;
    assign m_break_on_newline       = 1'b1;
    assign m_break_on_indented_line = m_brk_reg;
    assign m_section_gap_lines      = m_gap_reg;
    assign m_make_contents          = m_mc_reg;

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ptld_pkg::ST_EMIT)
        else $error("result raised outside the emit step");

    a_contents_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_mc_reg |-> !m_gap_reg[GW-1] && m_gap_reg != '0)
        else $error("contents flag without a positive section gap");

    a_indent_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_ind_reg != '0)
        else $error("ignored indent of zero");

    a_section_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ptld_pkg::ST_SECTION && found_reg |-> idx_reg >= start_reg)
        else $error("section walk passed its start bin");

endmodule

FILE: sv/plain_text_layout_detector.sv
// Top level of the plain text layout detector: configuration registers and block wiring.
//
// Input channel s_*: one text byte per word, s_end_of_text marks the end of a
// stream (its byte is ignored). Bytes are taken one per cycle while s_ready is high and
// produce no result; each newline updates the line counters and histograms in that cycle.
// Result channel m_*: one word per end word, with the layout guess.
// The end word starts a scan of the histograms through a single shared
// compare unit, one bin per cycle, in steps: the break flag, the indent
// pass, the best-gap search, the section pass and the load of the output
// register. s_ready is low during the scan.
// The result sits in an output register; while it waits, bytes of the next
// stream are taken, and a second end word holds in its last scan step until
// the receiver takes the first result. After the result loads, all counters
// and histograms clear.
// Reset (aresetn low, synchronous) clears the line state and histograms and loads the
// default configuration. Configuration is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
module plain_text_layout_detector #(
    parameter int TABLE_SIZE  = ptld_pkg::TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = ptld_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [ptld_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [ptld_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [7:0]                             s_text_byte,
    input  logic                                   s_end_of_text,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ptld_pkg::RESULT_W-1:0]          m_ignored_indent,
    output logic                                   m_break_on_empty_line,
    output logic                                   m_break_on_newline,
    output logic                                   m_break_on_indented_line,
    output logic signed [ptld_pkg::GAP_OUT_W-1:0]  m_section_gap_lines,
    output logic                                   m_make_contents
);

    localparam int IW = $clog2(TABLE_SIZE);

    ptld_pkg::cfg_t cfg_reg, cfg_next;

    logic                   run;
    logic                   clear;
    logic                   byte_en;
    logic                   end_accepted;
    logic [IW-1:0]          scan_idx;
    logic [COUNT_WIDTH-1:0] ih_bin;
    logic [COUNT_WIDTH-1:0] gh_bin;
    logic [COUNT_WIDTH-1:0] sh_bin;
    logic [COUNT_WIDTH-1:0] non_empty;
    logic [COUNT_WIDTH-1:0] not_long_total;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                ptld_pkg::CFG_SHORT_LINE_LIMIT:     cfg_next.short_line_limit = cfg_wdata;
                ptld_pkg::CFG_LINE_LIMIT:           cfg_next.line_limit = cfg_wdata;
                ptld_pkg::CFG_INDENT_SHARE_TENTHS:  cfg_next.indent_share_tenths =
                    cfg_wdata[ptld_pkg::SHARE_W-1:0];
                ptld_pkg::CFG_SHORT_SHARE_TENTHS:   cfg_next.short_share_tenths =
                    cfg_wdata[ptld_pkg::SHARE_W-1:0];
                ptld_pkg::CFG_SECTION_SHARE_TENTHS: cfg_next.section_share_tenths =
                    cfg_wdata[ptld_pkg::SHARE_W-1:0];
                ptld_pkg::CFG_SECTION_MIN_COUNT:    cfg_next.section_min_count = cfg_wdata;
                default: begin
                    // drop writes beyond the register list
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_line_limit     <= ptld_pkg::RST_SHORT_LINE_LIMIT;
            cfg_reg.line_limit           <= ptld_pkg::RST_LINE_LIMIT;
            cfg_reg.indent_share_tenths  <= ptld_pkg::RST_INDENT_SHARE_TENTHS;
            cfg_reg.short_share_tenths   <= ptld_pkg::RST_SHORT_SHARE_TENTHS;
            cfg_reg.section_share_tenths <= ptld_pkg::RST_SECTION_SHARE_TENTHS;
            cfg_reg.section_min_count    <= ptld_pkg::RST_SECTION_MIN_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready      = run;
    assign byte_en      = s_valid && run && !s_end_of_text;
    assign end_accepted = s_valid && run && s_end_of_text;

    ptld_stats #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_en        (byte_en),
        .text_byte      (s_text_byte),
        .clear          (clear),
        .cfg            (cfg_reg),
        .scan_en        (!run),
        .scan_idx       (scan_idx),
        .ih_bin         (ih_bin),
        .gh_bin         (gh_bin),
        .sh_bin         (sh_bin),
        .non_empty      (non_empty),
        .not_long_total (not_long_total)
    );

    ptld_seq #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .end_accepted             (end_accepted),
        .cfg                      (cfg_reg),
        .ih_bin                   (ih_bin),
        .gh_bin                   (gh_bin),
        .sh_bin                   (sh_bin),
        .non_empty                (non_empty),
        .not_long_total           (not_long_total),
        .run                      (run),
        .clear                    (clear),
        .scan_idx                 (scan_idx),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_ignored_indent         (m_ignored_indent),
        .m_break_on_empty_line    (m_break_on_empty_line),
        .m_break_on_newline       (m_break_on_newline),
        .m_break_on_indented_line (m_break_on_indented_line),
        .m_section_gap_lines      (m_section_gap_lines),
        .m_make_contents          (m_make_contents)
    );

endmodule

FILE: bench/tb_plain_text_layout_detector.sv
// Self-checking bench for the plain text layout detector: directed table, random streams.
module tb_plain_text_layout_detector;

    localparam int          TS            = ptld_pkg::TABLE_SIZE_DEF;
    localparam int          CW            = ptld_pkg::COUNT_WIDTH_DEF;
    localparam logic [63:0] CMAX          = (64'd1 << CW) - 64'd1;
    localparam int          NUM_PHASES    = 6;
    localparam int          RANDOM_WORDS  = 1400;
    localparam int          ENDS_PER_PASS = 2;
    localparam int          HOLD_CYCLES   = 1200;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [ptld_pkg::RESULT_W-1:0]         ignored_indent;
        logic                                  brk_empty;
        logic                                  brk_newline;
        logic                                  brk_indented;
        logic signed [ptld_pkg::GAP_OUT_W-1:0] gap_lines;
        logic                                  contents;
    } layout_res_t;

    typedef enum logic [1:0] {PIN_NONE, PIN_EMPTY, PIN_ONE_LINE} pin_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
        pin_t       pin;
    } dir_row_t;

    // Directed words; pinned rows carry a result that can be read off directly.
    localparam int DIR_LEN = 24;
    localparam dir_row_t DIR_TAB [DIR_LEN] = '{
        '{8'hFF, 1'b1, PIN_EMPTY},
        '{8'h41, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b1, PIN_ONE_LINE},
        '{ptld_pkg::CH_SP, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_HT, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_VT, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_FF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_CR, 1'b0, PIN_NONE},
        '{8'h80, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_SP, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{8'hFF, 1'b0, PIN_NONE},
        '{8'h00, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_CR, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{8'h7F, 1'b0, PIN_NONE},
        '{ptld_pkg::CH_LF, 1'b0, PIN_NONE},
        '{8'h5A, 1'b0, PIN_NONE},
        '{8'h00, 1'b1, PIN_NONE}
    };

    logic                                  aclk;
    logic                                  aresetn = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [ptld_pkg::CFG_IDX_W-1:0]        cfg_addr = '0;
    logic [ptld_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic [7:0]                            s_text_byte = '0;
    logic                                  s_end_of_text = 1'b0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic [ptld_pkg::RESULT_W-1:0]         m_ignored_indent;
    logic                                  m_break_on_empty_line;
    logic                                  m_break_on_newline;
    logic                                  m_break_on_indented_line;
    logic signed [ptld_pkg::GAP_OUT_W-1:0] m_section_gap_lines;
    logic                                  m_make_contents;
    pin_t                                  pin_sel = PIN_NONE;

    plain_text_layout_detector u_top (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .cfg_we                   (cfg_we),
        .cfg_addr                 (cfg_addr),
        .cfg_wdata                (cfg_wdata),
        .s_valid                  (s_valid),
        .s_ready                  (s_ready),
        .s_text_byte              (s_text_byte),
        .s_end_of_text            (s_end_of_text),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_ignored_indent         (m_ignored_indent),
        .m_break_on_empty_line    (m_break_on_empty_line),
        .m_break_on_newline       (m_break_on_newline),
        .m_break_on_indented_line (m_break_on_indented_line),
        .m_section_gap_lines      (m_section_gap_lines),
        .m_make_contents          (m_make_contents)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Predictor copy of the registers and the stream state.
    logic [63:0] lim_short, lim_line, share_indent, share_short, share_section, min_section;
    logic [63:0] n_lines, n_empty, n_not_long;
    logic [63:0] h_indent [TS];
    logic [63:0] h_gap [TS];
    logic [63:0] h_gap_short [TS];
    bit          cur_empty;
    int          cur_len, cur_ind, cur_gap;

    layout_res_t layout_q [$];
    layout_res_t predicted, got, want;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_requests = 0;
    int          holds_seen = 0;
    int          hold_left = 0;
    int          rx_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          burst_left = 0;
    bit          sender_steady = 0;
    int          phase_words, phase_ends;

    function automatic logic [63:0] bump(logic [63:0] v);
        return (v >= CMAX) ? CMAX : v + 64'd1;
    endfunction

    task automatic clear_stream();
        n_lines    = '0;
        n_empty    = CMAX;
        n_not_long = '0;
        for (int k = 0; k < TS; k++) begin
            h_indent[k]    = '0;
            h_gap[k]       = '0;
            h_gap_short[k] = '0;
        end
        cur_empty = 1;
        cur_len   = 0;
        cur_ind   = 0;
        cur_gap   = -1;
    endtask

    task automatic close_line();
        int bin;
        n_lines = bump(n_lines);
        if (cur_empty) begin
            if (n_empty == CMAX) n_empty = '0;
            else if (n_empty < CMAX - 64'd1) n_empty = n_empty + 64'd1;
            if (cur_gap < TS - 1) cur_gap++;
        end else begin
            if (cur_gap >= 0) begin
                bin = (cur_gap > TS - 1) ? TS - 1 : cur_gap;
                h_gap[bin] = bump(h_gap[bin]);
                if (64'(cur_len) < lim_short) h_gap_short[bin] = bump(h_gap_short[bin]);
            end
            cur_gap = -1;
        end
        if (64'(cur_len) < lim_line) n_not_long = bump(n_not_long);
        if (!cur_empty) begin
            bin = (cur_ind > TS - 1) ? TS - 1 : cur_ind;
            h_indent[bin] = bump(h_indent[bin]);
        end
        cur_empty = 1;
        cur_len   = 0;
        cur_ind   = 0;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        if (cur_len < 65535) cur_len++;
        if (b == ptld_pkg::CH_LF) begin
            close_line();
        end else if (b != ptld_pkg::CH_CR) begin
            if (b == ptld_pkg::CH_SP || b == ptld_pkg::CH_HT ||
                b == ptld_pkg::CH_VT || b == ptld_pkg::CH_FF) begin
                if (cur_empty && cur_ind < 15) cur_ind++;
            end else begin
                cur_empty = 0;
            end
        end
    endtask

    function automatic layout_res_t summarize_layout();
        logic [63:0] non_empty, cum, best, ga, sa;
        logic [63:0] gsum [TS];
        logic [63:0] ssum [TS];
        int          ind, sec, hit;
        layout_res_t r;
        non_empty = (n_lines - n_empty) & CMAX;
        cum = '0;
        ind = TS;
        for (int k = 0; k < TS; k++) begin
            cum = cum + h_indent[k];
            if (ind == TS && 64'd10 * cum > share_indent * non_empty) ind = k;
        end
        ind = ind + 1;
        if (ind > 15) ind = 15;
        best = '0;
        sec  = -1;
        for (int k = 2; k < TS; k++) begin
            if (best < h_gap_short[k]) begin
                best = h_gap_short[k];
                sec  = k;
            end
        end
        if (sec > 0) begin
            ga = '0;
            sa = '0;
            for (int k = TS - 1; k >= 0; k--) begin
                ga = ga + h_gap[k];
                sa = sa + h_gap_short[k];
                gsum[k] = ga;
                ssum[k] = sa;
            end
            hit = -1;
            for (int k = sec; k < TS; k++) begin
                if (hit < 0 && ssum[k] > min_section &&
                    64'd10 * ssum[k] > share_section * gsum[k]) hit = k;
            end
            sec = hit;
        end
        if (sec > 15) sec = 15;
        r.ignored_indent = ind[ptld_pkg::RESULT_W-1:0];
        r.brk_empty      = 1'b1;
        r.brk_newline    = 1'b1;
        r.brk_indented   = (64'd10 * n_not_long < share_short * non_empty) ? 1'b0 : 1'b1;
        r.gap_lines      = sec[ptld_pkg::GAP_OUT_W-1:0];
        r.contents       = (sec > 0);
        return r;
    endfunction

    function automatic layout_res_t pinned_layout(pin_t p);
        layout_res_t r;
        r.brk_empty   = 1'b1;
        r.brk_newline = 1'b1;
        r.gap_lines   = -5'sd1;
        r.contents    = 1'b0;
        if (p == PIN_EMPTY) begin
            // no lines: nothing reaches the indent share, short lines are a minority
            r.ignored_indent = 4'd11;
            r.brk_indented   = 1'b0;
        end else begin
            r.ignored_indent = 4'd1;
            r.brk_indented   = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, layout_res_t w, layout_res_t g);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at cycle %0d: expected ind=%0d e=%0b n=%0b i=%0b gap=%0d toc=%0b",
                     what, cycle_count,
                     w.ignored_indent, w.brk_empty, w.brk_newline, w.brk_indented,
                     w.gap_lines, w.contents);
            $display("    got ind=%0d e=%0b n=%0b i=%0b gap=%0d toc=%0b",
                     g.ignored_indent, g.brk_empty, g.brk_newline, g.brk_indented,
                     g.gap_lines, g.contents);
        end
    endtask

    // Monitor: predict on accepted input words, check accepted result words.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_end_of_text) begin
                    predicted = summarize_layout();
                    clear_stream();
                    layout_q.push_back(pin_sel == PIN_NONE ? predicted : pinned_layout(pin_sel));
                end else begin
                    absorb_byte(s_text_byte);
                end
            end
            if (m_valid && m_ready) begin
                got.ignored_indent = m_ignored_indent;
                got.brk_empty      = m_break_on_empty_line;
                got.brk_newline    = m_break_on_newline;
                got.brk_indented   = m_break_on_indented_line;
                got.gap_lines      = m_section_gap_lines;
                got.contents       = m_make_contents;
                if (layout_q.size() == 0) begin
                    note_mismatch("unexpected result", got, got);
                end else begin
                    want = layout_q.pop_front();
                    if (got.ignored_indent !== want.ignored_indent ||
                        got.brk_empty !== want.brk_empty ||
                        got.brk_newline !== want.brk_newline ||
                        got.brk_indented !== want.brk_indented ||
                        got.gap_lines !== want.gap_lines ||
                        got.contents !== want.contents)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Receiver: rotating stall patterns, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= (rx_left % 4 == 0);
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_plain_text_layout_detector failed");
        $finish;
    end

    // Drive one word and hold it until accepted; sometimes idle between bursts.
    task automatic send_word(logic [7:0] b, logic eot, pin_t p);
        if (burst_left == 0) begin
            if (!sender_steady && $urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= eot;
        pin_sel       <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_words++;
        if (eot) phase_ends++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (layout_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(ptld_pkg::cfg_idx_t idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            ptld_pkg::CFG_SHORT_LINE_LIMIT:     lim_short     = 64'(val);
            ptld_pkg::CFG_LINE_LIMIT:           lim_line      = 64'(val);
            ptld_pkg::CFG_INDENT_SHARE_TENTHS:  share_indent  = 64'(val[3:0]);
            ptld_pkg::CFG_SHORT_SHARE_TENTHS:   share_short   = 64'(val[3:0]);
            ptld_pkg::CFG_SECTION_SHARE_TENTHS: share_section = 64'(val[3:0]);
            default:                            min_section   = 64'(val);
        endcase
    endtask

    task automatic load_layout_cfg(logic [7:0] sl, logic [7:0] ll, logic [7:0] si,
                                   logic [7:0] ss, logic [7:0] sc, logic [7:0] mc);
        put_reg(ptld_pkg::CFG_SHORT_LINE_LIMIT, sl);
        put_reg(ptld_pkg::CFG_LINE_LIMIT, ll);
        put_reg(ptld_pkg::CFG_INDENT_SHARE_TENTHS, si);
        put_reg(ptld_pkg::CFG_SHORT_SHARE_TENTHS, ss);
        put_reg(ptld_pkg::CFG_SECTION_SHARE_TENTHS, sc);
        put_reg(ptld_pkg::CFG_SECTION_MIN_COUNT, mc);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return ptld_pkg::CH_SP;
            1:       return ptld_pkg::CH_HT;
            2:       return ptld_pkg::CH_VT;
            default: return ptld_pkg::CH_FF;
        endcase
    endfunction

    // Well-formed text: runs of empty lines, indented lines of mixed length.
    task automatic send_text_stream();
        int lines, gap, ind, len, r;
        lines = $urandom_range(1, 8);
        for (int ln = 0; ln < lines; ln++) begin
            r = $urandom_range(0, 99);
            gap = (r < 40) ? 0 : (r < 60) ? 1 : (r < 85) ? $urandom_range(2, 4)
                                                         : $urandom_range(5, 12);
            repeat (gap) begin
                repeat ($urandom_range(0, 2)) send_word(blank_byte(), 1'b0, PIN_NONE);
                if ($urandom_range(0, 4) == 0) send_word(ptld_pkg::CH_CR, 1'b0, PIN_NONE);
                send_word(ptld_pkg::CH_LF, 1'b0, PIN_NONE);
            end
            r = $urandom_range(0, 99);
            ind = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 18);
            repeat (ind) send_word(blank_byte(), 1'b0, PIN_NONE);
            r = $urandom_range(0, 99);
            len = (r < 65) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 40)
                                                             : $urandom_range(41, 100);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0) send_word(ptld_pkg::CH_SP, 1'b0, PIN_NONE);
                else send_word(8'($urandom_range(8'h21, 8'hFF)), 1'b0, PIN_NONE);
            end
            if ($urandom_range(0, 4) == 0) send_word(ptld_pkg::CH_CR, 1'b0, PIN_NONE);
            // leave the last line open now and then
            if (ln != lines - 1 || $urandom_range(0, 3) != 0)
                send_word(ptld_pkg::CH_LF, 1'b0, PIN_NONE);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1, PIN_NONE);
    endtask

    task automatic send_noise_stream();
        int n;
        n = $urandom_range(0, 40);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       send_word(ptld_pkg::CH_LF, 1'b0, PIN_NONE);
                1:       send_word(ptld_pkg::CH_CR, 1'b0, PIN_NONE);
                2:       send_word(blank_byte(), 1'b0, PIN_NONE);
                default: send_word(8'($urandom_range(0, 255)), 1'b0, PIN_NONE);
            endcase
        end
        send_word(8'($urandom_range(0, 255)), 1'b1, PIN_NONE);
    endtask

    initial begin
        lim_short     = 64'(ptld_pkg::RST_SHORT_LINE_LIMIT);
        lim_line      = 64'(ptld_pkg::RST_LINE_LIMIT);
        share_indent  = 64'(ptld_pkg::RST_INDENT_SHARE_TENTHS);
        share_short   = 64'(ptld_pkg::RST_SHORT_SHARE_TENTHS);
        share_section = 64'(ptld_pkg::RST_SECTION_SHARE_TENTHS);
        min_section   = 64'(ptld_pkg::RST_SECTION_MIN_COUNT);
        clear_stream();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: ;
                1: load_layout_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: load_layout_cfg(8'd255, 8'd255, 8'd15, 8'd15, 8'd15, 8'd255);
                3: load_layout_cfg(8'd255, 8'd255, 8'd10, 8'd10, 8'd10, 8'd0);
                4: load_layout_cfg(8'($urandom_range(0, 40)), 8'($urandom_range(0, 60)),
                                   8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                                   8'($urandom_range(0, 10)), 8'($urandom_range(0, 4)));
                default: load_layout_cfg(8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                                         8'($urandom_range(0, 15)), 8'($urandom_range(0, 3)));
            endcase
            sender_steady = (phase == 3);
            phase_words = 0;
            phase_ends  = 0;
            if (phase == 0) begin
                for (int k = 0; k < DIR_LEN; k++)
                    send_word(DIR_TAB[k].text, DIR_TAB[k].eot, DIR_TAB[k].pin);
                phase_words = 0;
                phase_ends  = 0;
            end
            // hold the result side off so the block backs up into its input
            if (phase == 2) hold_requests++;
            while (phase_words < RANDOM_WORDS / NUM_PHASES || phase_ends < ENDS_PER_PASS) begin
                if ($urandom_range(0, 99) < 85) send_text_stream();
                else send_noise_stream();
            end
            drain_results();
        end
        mismatches += layout_q.size();
        if (mismatches == 0)
            $display("tb_plain_text_layout_detector passed");
        else
            $display("tb_plain_text_layout_detector failed");
        $finish;
    end

endmodule

FILE: plain_text_layout_detector.f
sv/ptld_pkg.sv
sv/ptld_cmp.sv
sv/ptld_stats.sv
sv/ptld_seq.sv
sv/plain_text_layout_detector.sv
bench/tb_plain_text_layout_detector.sv
